[rtl/core/quaternion_to_euler_bins_defines.svh]
// Assertion macros shared by the quaternion-to-Euler block.
// No dependencies.
`ifndef QUATERNION_TO_EULER_BINS_DEFINES_SVH
`define QUATERNION_TO_EULER_BINS_DEFINES_SVH
// condition a implies b on every clock
`define Q2E_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("q2e check failed");
// condition a implies b on the following clock
`define Q2E_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("q2e check failed");
`endif

[rtl/core/q2e_pkg.sv]
// Types and constants for the quaternion-to-Euler bin block.
// No dependencies.
package q2e_pkg;
	localparam int AngW = 34;
	localparam int OpW  = 36;
	localparam int AtanEntries = 25;
	localparam logic signed [AngW-1:0] AngPi     = 34'sd2147483648;
	localparam logic signed [AngW-1:0] AngHalfPi = 34'sd1073741824;
	localparam logic signed [OpW-1:0]  OneQ28    = 36'sd268435456;

	typedef logic signed [AngW-1:0] ang_t;
	typedef logic signed [OpW-1:0]  op_t;

	typedef struct packed {
		op_t  x;
		op_t  y;
		ang_t z;
		logic zero_out;
	} cordic_t;

	function automatic ang_t atan_tab(input int i);
		case (i)
			0: atan_tab = 34'sd536870912;
			1: atan_tab = 34'sd316933406;
			2: atan_tab = 34'sd167458907;
			3: atan_tab = 34'sd85004756;
			4: atan_tab = 34'sd42667331;
			5: atan_tab = 34'sd21354465;
			6: atan_tab = 34'sd10679838;
			7: atan_tab = 34'sd5340245;
			8: atan_tab = 34'sd2670163;
			9: atan_tab = 34'sd1335087;
			10: atan_tab = 34'sd667544;
			11: atan_tab = 34'sd333772;
			12: atan_tab = 34'sd166886;
			13: atan_tab = 34'sd83443;
			14: atan_tab = 34'sd41722;
			15: atan_tab = 34'sd20861;
			16: atan_tab = 34'sd10430;
			17: atan_tab = 34'sd5215;
			18: atan_tab = 34'sd2608;
			19: atan_tab = 34'sd1304;
			20: atan_tab = 34'sd652;
			21: atan_tab = 34'sd326;
			22: atan_tab = 34'sd163;
			23: atan_tab = 34'sd81;
			24: atan_tab = 34'sd41;
			default: atan_tab = '0;
		endcase
	endfunction
endpackage

[rtl/core/q2e_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Self-contained, no package needed; stalls with the shared enable.
module q2e_isqrt #(
	parameter int InW = 57
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [InW-1:0]       rad,
	output logic [(InW+1)/2-1:0] root
);
	localparam int RW = (InW + 1) / 2;
	localparam int NW = 2 * RW;

	logic [NW-1:0] rem_s [RW+1];
	logic [RW-1:0] res_s [RW+1];

	assign rem_s[0] = NW'(rad);
	assign res_s[0] = '0;

	for (genvar k = 0; k < RW; k++) begin : g_st
		localparam int B = RW - 1 - k;
		logic [NW-1:0] trial;
		logic [NW-1:0] rem_n;
		logic [RW-1:0] res_n;
		always_comb begin
			trial = (NW'(res_s[k]) << (B + 1)) | (NW'(1) << (2 * B));
			if (rem_s[k] >= trial) begin
				rem_n = rem_s[k] - trial;
				res_n = res_s[k] | (RW'(1) << B);
			end else begin
				rem_n = rem_s[k];
				res_n = res_s[k];
			end
		end
		logic [NW-1:0] rem_q;
		logic [RW-1:0] res_q;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q <= rem_n;
				res_q <= res_n;
			end
		end
		assign rem_s[k+1] = rem_q;
		assign res_s[k+1] = res_q;
	end

	assign root = res_s[RW];
endmodule

[rtl/core/q2e_cordic.sv]
// Pipelined vectoring CORDIC arctangent, one rotation per stage.
// Depends on q2e_pkg; stalls with the shared enable.
module q2e_cordic #(
	parameter int Steps = 16
) (
	input  logic          clk,
	input  logic          en,
	input  q2e_pkg::op_t  y_in,
	input  q2e_pkg::op_t  x_in,
	output q2e_pkg::ang_t angle
);
	import q2e_pkg::*;
	localparam int N = (Steps > AtanEntries) ? AtanEntries : Steps;

	cordic_t st [N+1];
	cordic_t pre;
	cordic_t pre_s1;

	always_comb begin
		pre.x = x_in;
		pre.y = y_in;
		pre.z = '0;
		pre.zero_out = 1'b0;
		if (y_in == '0) begin
			pre.zero_out = 1'b1;
			pre.z = (x_in < 0) ? AngPi : '0;
		end else if (x_in == '0) begin
			pre.zero_out = 1'b1;
			pre.z = (y_in > 0) ? AngHalfPi : -AngHalfPi;
		end else if (x_in < 0) begin
			if (y_in > 0) begin
				pre.x = y_in;
				pre.y = -x_in;
				pre.z = AngHalfPi;
			end else begin
				pre.x = -y_in;
				pre.y = x_in;
				pre.z = -AngHalfPi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) pre_s1 <= pre;
	end
	assign st[0] = pre_s1;

	for (genvar i = 0; i < N; i++) begin : g_rot
		cordic_t nx;
		cordic_t r_q;
		always_comb begin
			nx = st[i];
			if (!st[i].zero_out) begin
				if (st[i].y > 0) begin
					nx.x = st[i].x + (st[i].y >>> i);
					nx.y = st[i].y - (st[i].x >>> i);
					nx.z = st[i].z + atan_tab(i);
				end else begin
					nx.x = st[i].x - (st[i].y >>> i);
					nx.y = st[i].y + (st[i].x >>> i);
					nx.z = st[i].z - atan_tab(i);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) r_q <= nx;
		end
		assign st[i+1] = r_q;
	end

	always_comb begin
		angle = st[N].z;
		if (angle > AngPi) angle = AngPi;
		if (angle < -AngPi) angle = -AngPi;
	end
endmodule

[rtl/core/quaternion_to_euler_bins.sv]
// Quaternion to coarse Euler-angle bins: top level.
// Depends on q2e_pkg, q2e_isqrt, q2e_cordic and the defines header.
//
// Usage:
//   s_axis carries one unit quaternion per item (w, x, y, z, signed Q2.14).
//   m_axis carries roll, pitch and yaw bins, each 0..BINS.
//   One item is accepted per cycle; the whole pipeline moves as one when
//   m_axis_tready is high or the output stage is empty, so throughput is
//   one item per cycle.
//   Pipeline: 2 product and operand stages, 29 square-root stages, 1 CORDIC
//   setup stage, CORDIC_STEPS rotation stages (at most 25), 1 bin stage.
//   The square root sets the depth.
//   When the receiver stalls, every stage holds and s_axis_tready drops;
//   nothing is lost or repeated.
//   Reset clears all valid bits; data registers are not reset.
//   No configuration; no state between items.
//
`include "quaternion_to_euler_bins_defines.svh"
module quaternion_to_euler_bins #(
	parameter int BINS = 18,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // roll_bin, pitch_bin, yaw_bin, pad
);
	import q2e_pkg::*;

	localparam int NC = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
	localparam int SQW = 57;
	localparam int SQD = (SQW + 1) / 2;
	localparam int DEPTH = 2 + SQD + 1 + NC + 1;

	logic en;
	logic [DEPTH-1:0] vld_q;

	assign en = !vld_q[DEPTH-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	// stage 1: products
	logic signed [15:0] w, x, y, z;
	assign w = s_axis_tdata[15:0];
	assign x = s_axis_tdata[31:16];
	assign y = s_axis_tdata[47:32];
	assign z = s_axis_tdata[63:48];

	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= w * x;
			yz_s1 <= y * z;
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			wz_s1 <= w * z;
			xy_s1 <= x * y;
			zz_s1 <= z * z;
			wy_s1 <= w * y;
			zx_s1 <= z * x;
		end
	end

	// stage 2: operands, clamped sine, radicand
	op_t rn_s2, rd_s2, yn_s2, yd_s2, s_s2;
	op_t s_c;
	logic [SQW-1:0] rad_s2;
	always_comb begin
		s_c = (OpW'(wy_s1) - OpW'(zx_s1)) <<< 1;
		if (s_c > OneQ28) s_c = OneQ28;
		if (s_c < -OneQ28) s_c = -OneQ28;
	end
	logic [28:0] s_mag;
	logic [57:0] sq;
	always_comb begin
		s_mag = (s_c < 0) ? 29'(-s_c) : 29'(s_c);
		sq = 58'(s_mag) * 58'(s_mag);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rn_s2 <= (OpW'(wx_s1) + OpW'(yz_s1)) <<< 1;
			rd_s2 <= OneQ28 - ((OpW'(xx_s1) + OpW'(yy_s1)) <<< 1);
			yn_s2 <= (OpW'(wz_s1) + OpW'(xy_s1)) <<< 1;
			yd_s2 <= OneQ28 - ((OpW'(yy_s1) + OpW'(zz_s1)) <<< 1);
			s_s2  <= s_c;
			rad_s2 <= SQW'((58'd1 << 56) - sq);
		end
	end

	logic [SQD-1:0] c_root;
	q2e_isqrt #(.InW(SQW)) u_sqrt (
		.clk(clk), .en(en), .rad(rad_s2), .root(c_root)
	);

	op_t dly_q [SQD][5];
	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= '{rn_s2, rd_s2, yn_s2, yd_s2, s_s2};
			for (int k = 1; k < SQD; k++) dly_q[k] <= dly_q[k-1];
		end
	end

	ang_t roll, pitch, yaw;
	q2e_cordic #(.Steps(CORDIC_STEPS)) u_roll (
		.clk(clk), .en(en), .y_in(dly_q[SQD-1][0]), .x_in(dly_q[SQD-1][1]), .angle(roll)
	);
	q2e_cordic #(.Steps(CORDIC_STEPS)) u_pitch (
		.clk(clk), .en(en), .y_in(dly_q[SQD-1][4]), .x_in(OpW'(c_root)), .angle(pitch)
	);
	q2e_cordic #(.Steps(CORDIC_STEPS)) u_yaw (
		.clk(clk), .en(en), .y_in(dly_q[SQD-1][2]), .x_in(dly_q[SQD-1][3]), .angle(yaw)
	);

	// bin stage
	ang_t pc;
	logic [32:0] ur, up, uy;
	logic [40:0] pr, pp, py;
	always_comb begin
		pc = pitch;
		if (pc > AngHalfPi) pc = AngHalfPi;
		if (pc < -AngHalfPi) pc = -AngHalfPi;
		ur = 33'(roll + AngPi);
		up = 33'(pc + AngHalfPi);
		uy = 33'(yaw + AngPi);
		pr = 41'(ur) * 41'(BINS);
		pp = 41'(up) * 41'(BINS);
		py = 41'(uy) * 41'(BINS);
	end

	logic [4:0] roll_s, pitch_s, yaw_s;
	always_ff @(posedge clk) begin
		if (en) begin
			roll_s  <= pr[36:32];
			pitch_s <= pp[35:31];
			yaw_s   <= py[36:32];
		end
	end
	assign m_axis_tdata = {1'b0, yaw_s, pitch_s, roll_s};

	`Q2E_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	`Q2E_ASSERT_IMP(a_ready, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`Q2E_ASSERT_IMP(a_bins, clk, arst_n, m_axis_tvalid && BINS < 32,
		m_axis_tdata[4:0] <= 5'(BINS) && m_axis_tdata[9:5] <= 5'(BINS))
endmodule

[tb/sv/quaternion_to_euler_bins_checker.sv]
`timescale 1ns / 100ps
// Checker for quaternion_to_euler_bins: predicts roll/pitch/yaw bins for each
// accepted quaternion item and compares them with each delivered result item.
// Depends on nothing but the stream ports of the block.
module quaternion_to_euler_bins_checker #(
	parameter int BINS = 18,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	output int          fail_count,
	output int          bins_pending,
	output int          bins_checked
);
	localparam longint PiAng = 64'sd2147483648;
	localparam longint HalfPiAng = 64'sd1073741824;
	localparam longint OneFix = 64'sd268435456;

	typedef struct packed {
		logic [4:0] roll;
		logic [4:0] pitch;
		logic [4:0] yaw;
	} euler_bins_t;

	euler_bins_t bins_q[$];

	function automatic longint arctan_step(input int i);
		longint steps[25] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41};
		return steps[i];
	endfunction

	function automatic longint floor_sqrt(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint vector_angle(input longint sy, input longint cx);
		longint ang, t, dx, dy;
		int n;
		ang = 0;
		if (sy == 0) return (cx < 0) ? PiAng : 0;
		if (cx == 0) return (sy > 0) ? HalfPiAng : -HalfPiAng;
		if (cx < 0) begin
			t = cx;
			if (sy > 0) begin
				cx = sy; sy = -t; ang = HalfPiAng;
			end else begin
				cx = -sy; sy = t; ang = -HalfPiAng;
			end
		end
		n = (CORDIC_STEPS > 25) ? 25 : CORDIC_STEPS;
		for (int i = 0; i < n; i++) begin
			dx = sy >>> i;
			dy = cx >>> i;
			if (sy > 0) begin
				cx += dx; sy -= dy; ang += arctan_step(i);
			end else begin
				cx -= dx; sy += dy; ang -= arctan_step(i);
			end
		end
		if (ang > PiAng) ang = PiAng;
		if (ang < -PiAng) ang = -PiAng;
		return ang;
	endfunction

	function automatic euler_bins_t quat_to_bins(input logic [63:0] q);
		longint w, x, y, z, s, c, roll, pitch, yaw;
		longint unsigned u;
		euler_bins_t r;
		w = longint'($signed(q[15:0]));
		x = longint'($signed(q[31:16]));
		y = longint'($signed(q[47:32]));
		z = longint'($signed(q[63:48]));
		s = 2 * (w * y - z * x);
		if (s > OneFix) s = OneFix;
		if (s < -OneFix) s = -OneFix;
		c = floor_sqrt(longint'(OneFix * OneFix - s * s));
		roll = vector_angle(2 * (w * x + y * z), OneFix - 2 * (x * x + y * y));
		pitch = vector_angle(s, c);
		yaw = vector_angle(2 * (w * z + x * y), OneFix - 2 * (y * y + z * z));
		if (pitch > HalfPiAng) pitch = HalfPiAng;
		if (pitch < -HalfPiAng) pitch = -HalfPiAng;
		u = roll + PiAng;
		r.roll = 5'((u * BINS) >> 32);
		u = pitch + HalfPiAng;
		r.pitch = 5'((u * BINS) >> 31);
		u = yaw + PiAng;
		r.yaw = 5'((u * BINS) >> 32);
		return r;
	endfunction

	always @(posedge clk) begin
		euler_bins_t want;
		if (!arst_n) begin
			bins_q.delete();
			fail_count = 0;
			bins_checked = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				bins_q.push_back(quat_to_bins(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (bins_q.size() == 0) begin
					$error("result item with no quaternion pending: %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = bins_q.pop_front();
					bins_checked++;
					if (m_axis_tdata[4:0] !== want.roll) begin
						$error("roll_bin expected %0d got %0d", want.roll, m_axis_tdata[4:0]);
						fail_count++;
					end
					if (m_axis_tdata[9:5] !== want.pitch) begin
						$error("pitch_bin expected %0d got %0d", want.pitch, m_axis_tdata[9:5]);
						fail_count++;
					end
					if (m_axis_tdata[14:10] !== want.yaw) begin
						$error("yaw_bin expected %0d got %0d", want.yaw, m_axis_tdata[14:10]);
						fail_count++;
					end
				end
			end
		end
		bins_pending = bins_q.size();
	end
endmodule

[tb/sv/quaternion_to_euler_bins_tb.sv]
`timescale 1ns / 100ps
// Top of the quaternion_to_euler_bins testbench: clock, reset, quaternion
// stimulus, receiver stalls and verdict. Uses quaternion_to_euler_bins_checker.
module quaternion_to_euler_bins_tb;
	localparam int RandomItems = 1280;
	localparam int IdleLimit = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	int          fail_count, bins_pending, bins_checked;
	int          send_idle_pct, recv_idle_pct;
	int          idle_cycles;
	int          sent;

	quaternion_to_euler_bins dut (.*);

	quaternion_to_euler_bins_checker chk (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		send_idle_pct = 31;
		recv_idle_pct = 65;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(negedge clk)
		if (arst_n) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("watchdog: no progress for %0d cycles", IdleLimit);
			$display("TB_ERROR");
			$finish;
		end
	end
	initial idle_cycles = 0;

	task automatic send_quat(input logic [15:0] w, x, y, z);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {z, y, x, w};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic send_random;
		real a, b, c, d, n;
		if ($urandom_range(99) < 70) begin
			a = real'($signed(16'($urandom))); b = real'($signed(16'($urandom)));
			c = real'($signed(16'($urandom))); d = real'($signed(16'($urandom)));
			n = $sqrt(a * a + b * b + c * c + d * d);
			if (n < 1.0) n = 1.0;
			send_quat(16'($rtoi(a * 16384.0 / n)), 16'($rtoi(b * 16384.0 / n)),
				16'($rtoi(c * 16384.0 / n)), 16'($rtoi(d * 16384.0 / n)));
		end else begin
			send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		sent = 0;
		wait (arst_n);
		// extremes, identity and axis rotations
		send_quat(16'd0, 16'd0, 16'd0, 16'd0);
		send_quat(16'd16384, 16'd0, 16'd0, 16'd0);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_quat(16'd0, 16'd16384, 16'd0, 16'd0);
		send_quat(16'd0, 16'd0, 16'd16384, 16'd0);
		send_quat(16'd0, 16'd0, 16'd0, 16'd16384);
		send_quat(16'd11585, 16'd11585, 16'd0, 16'd0);
		send_quat(16'd11585, 16'd0, 16'd0, -16'sd11585);
		// pitch at +/- half pi, sine clamped
		send_quat(16'd11585, 16'd0, 16'd11585, 16'd0);
		send_quat(16'd11585, 16'd0, -16'sd11585, 16'd0);
		send_quat(16'd16384, 16'd0, 16'd16384, 16'd0);
		send_quat(16'd16384, 16'd0, -16'sd16384, 16'd0);
		// zero cosine operand for roll and yaw
		send_quat(16'd8192, 16'd8192, 16'd8192, 16'd0);
		send_quat(-16'sd8192, 16'd8192, 16'd8192, 16'd0);
		send_quat(16'd8192, 16'd0, 16'd8192, 16'd8192);
		// zero sine with negative cosine
		send_quat(16'd0, 16'd0, 16'd16384, 16'd0);
		send_quat(16'd0, 16'd8192, 16'd8192, 16'd0);
		for (int i = 0; i < RandomItems; i++) begin
			if (i == RandomItems / 3) begin
				send_idle_pct = 65; recv_idle_pct = 31;
			end else if (i == 2 * RandomItems / 3) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			send_random();
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (bins_pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("sent %0d quaternions (directed corners and %0d random), checked %0d results",
			sent, RandomItems, bins_checked);
		if (fail_count == 0 && bins_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
